// File: rtl/core/gaussian_elimination_3x3_solver_unit_macros.svh
// Assertion macros used by the solve engine RTL
`ifndef GAUSSIAN_ELIMINATION_3X3_SOLVER_UNIT_MACROS_SVH
`define GAUSSIAN_ELIMINATION_3X3_SOLVER_UNIT_MACROS_SVH

// same-cycle implication
`define GESU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GESU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gesu_pkg.sv
// Shared constants, types, saturation helper and solve program for the solver
`default_nettype none
package gesu_pkg;

  localparam int WORD_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int IO_WIDTH          = 32;
  localparam int SAT_W             = 65;
  localparam int ADDR_W            = 4;
  localparam int MEM_DEPTH         = 16;
  localparam int PC_W              = 6;
  localparam logic [PC_W-1:0] PROG_LAST = PC_W'(39);
  localparam logic [1:0] LAST_ROW  = 2'd2;
  localparam logic [1:0] LAST_WORD = 2'd3;

  typedef enum logic [2:0] {
    OP_CHK,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] d;
    logic [1:0]        xs;
  } uop_t;

  typedef struct packed {
    logic                    clip;
    logic signed [SAT_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_fit(input logic signed [SAT_W-1:0] v, input int unsigned w);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] top;
    sat_t r;
    hi = v >>> (w - 1);
    top = {{(SAT_W-1){1'b0}}, 1'b1} <<< (w - 1);
    r.clip = !((hi == '0) || (hi == '1));
    if (!r.clip) begin
      r.val = v;
    end else if (v[SAT_W-1]) begin
      r.val = -top;
    end else begin
      r.val = top - {{(SAT_W-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_t op, input int a, input int b, input int d,
                              input int xs);
    uop_t u;
    u.op = op;
    u.a  = ADDR_W'(a);
    u.b  = ADDR_W'(b);
    u.d  = ADDR_W'(d);
    u.xs = 2'(xs);
    return u;
  endfunction

  // entries 0..11 hold the augmented rows, 12 the ratio, 13 and 14 scratch
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_CHK, 0, 0, 0, 0);
      6'd1:  u = mk(OP_DIV, 4, 0, 12, 0);
      6'd2:  u = mk(OP_MUL, 12, 0, 13, 0);
      6'd3:  u = mk(OP_SUB, 4, 13, 4, 0);
      6'd4:  u = mk(OP_MUL, 12, 1, 13, 0);
      6'd5:  u = mk(OP_SUB, 5, 13, 5, 0);
      6'd6:  u = mk(OP_MUL, 12, 2, 13, 0);
      6'd7:  u = mk(OP_SUB, 6, 13, 6, 0);
      6'd8:  u = mk(OP_MUL, 12, 3, 13, 0);
      6'd9:  u = mk(OP_SUB, 7, 13, 7, 0);
      6'd10: u = mk(OP_DIV, 8, 0, 12, 0);
      6'd11: u = mk(OP_MUL, 12, 0, 13, 0);
      6'd12: u = mk(OP_SUB, 8, 13, 8, 0);
      6'd13: u = mk(OP_MUL, 12, 1, 13, 0);
      6'd14: u = mk(OP_SUB, 9, 13, 9, 0);
      6'd15: u = mk(OP_MUL, 12, 2, 13, 0);
      6'd16: u = mk(OP_SUB, 10, 13, 10, 0);
      6'd17: u = mk(OP_MUL, 12, 3, 13, 0);
      6'd18: u = mk(OP_SUB, 11, 13, 11, 0);
      6'd19: u = mk(OP_CHK, 5, 0, 0, 0);
      6'd20: u = mk(OP_DIV, 9, 5, 12, 0);
      6'd21: u = mk(OP_MUL, 12, 4, 13, 0);
      6'd22: u = mk(OP_SUB, 8, 13, 8, 0);
      6'd23: u = mk(OP_MUL, 12, 5, 13, 0);
      6'd24: u = mk(OP_SUB, 9, 13, 9, 0);
      6'd25: u = mk(OP_MUL, 12, 6, 13, 0);
      6'd26: u = mk(OP_SUB, 10, 13, 10, 0);
      6'd27: u = mk(OP_MUL, 12, 7, 13, 0);
      6'd28: u = mk(OP_SUB, 11, 13, 11, 0);
      6'd29: u = mk(OP_CHK, 10, 0, 0, 0);
      6'd30: u = mk(OP_DIV, 11, 10, 11, 3);
      6'd31: u = mk(OP_MUL, 6, 11, 13, 0);
      6'd32: u = mk(OP_SUB, 7, 13, 7, 0);
      6'd33: u = mk(OP_DIV, 7, 5, 7, 2);
      6'd34: u = mk(OP_MUL, 1, 7, 13, 0);
      6'd35: u = mk(OP_MUL, 2, 11, 14, 0);
      6'd36: u = mk(OP_ADD, 13, 14, 13, 0);
      6'd37: u = mk(OP_SUB, 3, 13, 3, 0);
      6'd38: u = mk(OP_DIV, 3, 0, 3, 1);
      default: u = mk(OP_END, 0, 0, 0, 0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/gesu_front.sv
// Front end: accepts rows, clips them to the word range and tags the row number
`default_nettype none
module gesu_front #(
  parameter int WORD_WIDTH = gesu_pkg::WORD_WIDTH_DEF,
  parameter int ENTRY_W    = 4 * WORD_WIDTH + 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  in_coef_first,
  input  wire logic signed [31:0]  in_coef_second,
  input  wire logic signed [31:0]  in_coef_third,
  input  wire logic signed [31:0]  in_rhs,
  output logic                     q_push,
  output logic [ENTRY_W-1:0]       q_data,
  input  wire logic                q_full
);

  logic [1:0]      row_r;
  logic [1:0]      row_nxt;
  gesu_pkg::sat_t  s0, s1, s2, s3;

  always_comb begin
    s0 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(in_coef_first), WORD_WIDTH);
    s1 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(in_coef_second), WORD_WIDTH);
    s2 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(in_coef_third), WORD_WIDTH);
    s3 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(in_rhs), WORD_WIDTH);
    q_data = {row_r, (s0.clip | s1.clip | s2.clip | s3.clip),
              s3.val[WORD_WIDTH-1:0], s2.val[WORD_WIDTH-1:0],
              s1.val[WORD_WIDTH-1:0], s0.val[WORD_WIDTH-1:0]};
    in_stall = q_full;
    q_push = in_valid && !q_full;
    row_nxt = (row_r == gesu_pkg::LAST_ROW) ? 2'd0 : row_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 2'd0;
    end else if (q_push) begin
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gesu_queue.sv
// Two-entry queue between the front end and the solve engine
`default_nettype none
module gesu_queue #(
  parameter int ENTRY_W = 4 * gesu_pkg::WORD_WIDTH_DEF + 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [ENTRY_W-1:0] push_data,
  output logic                    full,
  output logic                    pop_valid,
  output logic [ENTRY_W-1:0]      pop_data,
  input  wire logic               pop
);

  logic [ENTRY_W-1:0] ent_r [2];
  logic               wp_r;
  logic               rp_r;
  logic [1:0]         cnt_r;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    full = (cnt_r == 2'd2);
    pop_valid = (cnt_r != 2'd0);
    pop_data = ent_r[rp_r];
    do_push = push && !full;
    do_pop = pop && pop_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gesu_back.sv
// Solve engine: row store, microprogram sequencer, serial multiplier and divider
`default_nettype none
`include "gaussian_elimination_3x3_solver_unit_macros.svh"
module gesu_back #(
  parameter int WORD_WIDTH    = gesu_pkg::WORD_WIDTH_DEF,
  parameter int FRACTION_BITS = gesu_pkg::FRACTION_BITS_DEF,
  parameter int ENTRY_W       = 4 * WORD_WIDTH + 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x_first,
  output logic signed [31:0]      out_x_second,
  output logic signed [31:0]      out_x_third,
  output logic                    out_zero_pivot,
  output logic                    out_saturated
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W + 1;
  localparam int QW = W + F;
  localparam int MW = PW + F;
  localparam int CW = $clog2(QW);
  localparam int AW = gesu_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_FETCH,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB,
    S_FIN
  } state_t;

  state_t                       state_r;
  logic [gesu_pkg::PC_W-1:0]    pc_r;
  logic [1:0]                   k_r;
  logic                         clip_r;
  logic                         zp_r;
  logic                         neg_r;
  logic [CW-1:0]                cnt_r;
  logic [W-1:0]                 opa_r;
  logic [W-1:0]                 opb_r;
  logic [2*W-1:0]               acc_r;
  logic [QW-1:0]                num_r;
  logic [QW-1:0]                quo_r;
  logic [W-1:0]                 rem_r;
  logic signed [W-1:0]          rda_r;
  logic signed [W-1:0]          rdb_r;
  logic signed [W-1:0]          x0_r, x1_r, x2_r;
  logic out_valid_r;
  logic signed [31:0]           ox0_r, ox1_r, ox2_r;
  logic                         ozp_r;
  logic                         osat_r;
  logic signed [W-1:0]          mem [gesu_pkg::MEM_DEPTH];

  gesu_pkg::uop_t               uop;
  logic [1:0]                   q_row;
  logic                         q_clip;
  logic                         we;
  logic [AW-1:0]                wa;
  logic signed [W-1:0]          wd;
  logic                         wclip;
  gesu_pkg::sat_t               as;
  logic [W:0]                   rem2;
  logic                         ge;
  logic [MW-1:0]                mag;
  logic [MW-1:0]                lim;
  logic                         mclip;
  logic [MW-1:0]                mval;
  logic signed [W-1:0]          msat;
  logic [PW-1:0]                half;
  gesu_pkg::sat_t               o0, o1, o2;
  logic                         out_free;

  function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  always_comb begin
    uop = gesu_pkg::prog(pc_r);
    q_row = q_data[ENTRY_W-1 -: 2];
    q_clip = q_data[4*W];
    q_pop = (state_r == S_WR) && (k_r == gesu_pkg::LAST_WORD);
    out_free = !out_valid_r || !out_stall;

    if (uop.op == gesu_pkg::OP_SUB) begin
      as = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(rda_r) - gesu_pkg::SAT_W'(rdb_r), W);
    end else begin
      as = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(rda_r) + gesu_pkg::SAT_W'(rdb_r), W);
    end

    rem2 = {rem_r, num_r[QW-1]};
    ge = rem2 >= {1'b0, opb_r};

    half = PW'(1) << (F - 1);
    if (uop.op == gesu_pkg::OP_DIV) begin
      mag = MW'(quo_r) + MW'({rem_r, 1'b0} >= {1'b0, opb_r});
    end else begin
      mag = MW'(({1'b0, acc_r} + half) >> F);
    end
    lim = (MW'(1) << (W - 1)) - MW'(!neg_r);
    mclip = mag > lim;
    mval = mclip ? lim : mag;
    msat = neg_r ? W'(-mval) : W'(mval);

    we = 1'b0;
    wa = uop.d;
    wd = as.val[W-1:0];
    wclip = 1'b0;
    case (state_r)
      S_WR: begin
        we = 1'b1;
        wa = {q_row, k_r};
        wd = q_data[k_r*W +: W];
      end
      S_EXEC: begin
        if (uop.op == gesu_pkg::OP_ADD || uop.op == gesu_pkg::OP_SUB) begin
          we = 1'b1;
          wclip = as.clip;
        end
      end
      S_WB: begin
        we = 1'b1;
        wd = msat;
        wclip = mclip;
      end
      default: begin
        we = 1'b0;
      end
    endcase

    o0 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(x0_r), gesu_pkg::IO_WIDTH);
    o1 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(x1_r), gesu_pkg::IO_WIDTH);
    o2 = gesu_pkg::sat_fit(gesu_pkg::SAT_W'(x2_r), gesu_pkg::IO_WIDTH);

    out_valid = out_valid_r;
    out_x_first = ox0_r;
    out_x_second = ox1_r;
    out_x_third = ox2_r;
    out_zero_pivot = ozp_r;
    out_saturated = osat_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[uop.a];
    rdb_r <= mem[uop.b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      k_r         <= 2'd0;
      clip_r      <= 1'b0;
      zp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wclip) begin
        clip_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          k_r <= 2'd0;
          if (q_valid) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          k_r <= k_r + 2'd1;
          if (k_r == gesu_pkg::LAST_WORD) begin
            clip_r <= ((q_row == 2'd0) ? 1'b0 : clip_r) | q_clip;
            if (q_row == gesu_pkg::LAST_ROW) begin
              pc_r    <= '0;
              zp_r    <= 1'b0;
              state_r <= S_FETCH;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FETCH: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          neg_r <= rda_r[W-1] ^ rdb_r[W-1];
          opa_r <= mag_of(rda_r);
          opb_r <= mag_of(rdb_r);
          acc_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
          num_r <= {mag_of(rda_r), {F{1'b0}}};
          case (uop.op)
            gesu_pkg::OP_CHK: begin
              if (rda_r == '0) begin
                zp_r    <= 1'b1;
                state_r <= S_FIN;
              end else begin
                pc_r    <= pc_r + gesu_pkg::PC_W'(1);
                state_r <= S_FETCH;
              end
            end
            gesu_pkg::OP_ADD, gesu_pkg::OP_SUB: begin
              pc_r    <= pc_r + gesu_pkg::PC_W'(1);
              state_r <= S_FETCH;
            end
            gesu_pkg::OP_MUL: begin
              cnt_r   <= CW'(W - 1);
              state_r <= S_MUL;
            end
            gesu_pkg::OP_DIV: begin
              cnt_r   <= CW'(QW - 1);
              state_r <= S_DIV;
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          acc_r <= {acc_r[2*W-2:0], 1'b0} + (opb_r[W-1] ? (2*W)'(opa_r) : '0);
          opb_r <= {opb_r[W-2:0], 1'b0};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_WB;
          end
        end
        S_DIV: begin
          rem_r <= ge ? W'(rem2 - {1'b0, opb_r}) : W'(rem2);
          quo_r <= {quo_r[QW-2:0], ge};
          num_r <= {num_r[QW-2:0], 1'b0};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          case (uop.xs)
            2'd1: x0_r <= msat;
            2'd2: x1_r <= msat;
            2'd3: x2_r <= msat;
            default: begin
            end
          endcase
          pc_r    <= pc_r + gesu_pkg::PC_W'(1);
          state_r <= S_FETCH;
        end
        S_FIN: begin
          if (out_free) begin
            ozp_r       <= zp_r;
            ox0_r       <= zp_r ? '0 : o0.val[31:0];
            ox1_r       <= zp_r ? '0 : o1.val[31:0];
            ox2_r       <= zp_r ? '0 : o2.val[31:0];
            osat_r      <= !zp_r && (clip_r | o0.clip | o1.clip | o2.clip);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `GESU_ASSERT_NOW(a_zp_zero, out_valid_r && ozp_r, ox0_r == '0 && ox1_r == '0 && ox2_r == '0 && !osat_r, "zero pivot result not cleared")
  `GESU_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  `GESU_ASSERT_NOW(a_pc_range, state_r == S_FETCH, pc_r <= gesu_pkg::PROG_LAST, "program counter out of range")
  `GESU_ASSERT_NEXT(a_start, q_pop && q_row == gesu_pkg::LAST_ROW, state_r == S_FETCH && pc_r == '0, "solve did not start")

endmodule
`default_nettype wire

// File: rtl/core/gaussian_elimination_3x3_solver_unit.sv
// Solver for a 3x3 linear system in signed fixed point: top level
//
// Input channel (in_valid / in_stall): one word per row of the augmented
// matrix, three coefficients and the right-hand side, rows in order.
// Output channel (out_valid / out_stall): one word per three rows, holding
// the three unknowns, a zero-pivot flag and a saturation flag.
// Rows pass a two-entry queue; the solve engine copies each into its row
// store word by word. After the third row it runs a 40-step program on one
// shared serial multiplier and one restoring divider: 15 products,
// 6 quotients, and the zero-pivot checks, add/sub steps and finish step.
// A zero pivot ends the program early with zeroed unknowns.
// Rows are taken while the engine solves, until the queue fills.
// A stalled result holds in the output register; the engine loads the
// next system meanwhile and waits only to present its result.
// Reset clears the row counter, the queue and all valid flags.
`default_nettype none
module gaussian_elimination_3x3_solver_unit #(
  parameter int WORD_WIDTH    = gesu_pkg::WORD_WIDTH_DEF,
  parameter int FRACTION_BITS = gesu_pkg::FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_coef_first,
  input  wire logic signed [31:0] in_coef_second,
  input  wire logic signed [31:0] in_coef_third,
  input  wire logic signed [31:0] in_rhs,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x_first,
  output logic signed [31:0]      out_x_second,
  output logic signed [31:0]      out_x_third,
  output logic                    out_zero_pivot,
  output logic                    out_saturated
);

  localparam int ENTRY_W = 4 * WORD_WIDTH + 3;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               full;
  logic               pop_valid;
  logic [ENTRY_W-1:0] pop_data;
  logic               pop;

  gesu_front #(
    .WORD_WIDTH (WORD_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coef_first  (in_coef_first),
    .in_coef_second (in_coef_second),
    .in_coef_third  (in_coef_third),
    .in_rhs         (in_rhs),
    .q_push         (push),
    .q_data         (push_data),
    .q_full         (full)
  );

  gesu_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop)
  );

  gesu_back #(
    .WORD_WIDTH    (WORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_first    (out_x_first),
    .out_x_second   (out_x_second),
    .out_x_third    (out_x_third),
    .out_zero_pivot (out_zero_pivot),
    .out_saturated  (out_saturated)
  );

endmodule
`default_nettype wire
